// ----- sv/assert_macros.svh -----
// Assertion macros shared by the timer bank RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on clk_i, ignored while rst_ni is low.
`define STB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on clk_i at every edge, reset included.
`define STB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define STB_ASSERT(lbl, prop, msg)
`define STB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/stb_pkg.sv -----
// Types, codes and constants of the timer bank.
package stb_pkg;

  localparam int TIMER_SLOTS_DEF = 8;
  localparam int SLOT_IDX_W      = 4;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int IN_DATA_W       = 64;
  localparam int OUT_DATA_W      = 144;

  localparam logic [11:0] MS_PER_SECOND = 12'd1000;

  // Config register indexes and reset values
  localparam logic [CFG_ADDR_W-1:0] CFG_TICK_RATE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MS_WHOLE      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MS_FRACTION   = 2'd2;
  localparam logic [9:0]  TICK_RATE_RST     = 10'd10;
  localparam logic [9:0]  MS_WHOLE_RST      = 10'd0;
  localparam logic [31:0] MS_FRACTION_RST   = 32'd429496730;

  // Input commands
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_CREATE = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  // Slot modes
  localparam logic [1:0] MODE_FREE     = 2'd0;
  localparam logic [1:0] MODE_ONESHOT  = 2'd1;
  localparam logic [1:0] MODE_PERIODIC = 2'd2;

  typedef enum logic [1:0] {
    KIND_FIRED  = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_CREATE = 2'd2,
    KIND_REMOVE = 2'd3
  } result_kind_e;

  // Controller to datapath
  typedef struct packed {
    logic         latch;    // capture the input beat
    logic         advance;  // step tick counter and ms accumulator
    logic         scan;     // act on the slot under scan if it fires
    logic         mul;      // form period, pick free slot
    logic         create;   // write the picked slot
    logic         remove;   // clear the addressed slot
    logic         emit;     // load the output register
    result_kind_e kind;
    logic         last;
  } stb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;       // slot under scan fires
    logic out_free;  // output register can take a beat
  } stb_status_t;

endpackage

// ----- sv/stb_ctrl.sv -----
// Controller: sequences ticks, slot scan, create, remove and no-op status replies.
`include "assert_macros.svh"
module stb_ctrl import stb_pkg::*; #(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
  localparam int IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_cmd_i,
  output logic            in_ready_o,
  input  stb_status_t     status_i,
  output stb_cmd_t        cmd_o,
  output logic [IdxW-1:0] scan_idx_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_STATUS = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_CREATE = 3'd4;
  localparam logic [2:0] ST_REMOVE = 3'd5;

  localparam logic [IdxW-1:0] IdxTop = IdxW'(TIMER_SLOTS - 1);

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign scan_idx_o = idx_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.kind = KIND_STATUS;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.latch = 1'b1;
          unique case (in_cmd_i)
            CMD_TICK: begin
              cmd_o.advance = 1'b1;
              idx_d   = IdxTop;
              state_d = ST_SCAN;
            end
            CMD_CREATE: state_d = ST_MUL;
            CMD_REMOVE: state_d = ST_REMOVE;
            default:    state_d = ST_STATUS;
          endcase
        end
      end
      ST_SCAN: begin
        // a firing slot waits for room in the output register
        if (!status_i.hit || status_i.out_free) begin
          cmd_o.scan = 1'b1;
          cmd_o.emit = status_i.hit;
          cmd_o.kind = KIND_FIRED;
          if (idx_q == '0) begin
            state_d = ST_STATUS;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      ST_STATUS: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_CREATE;
      end
      ST_CREATE: begin
        if (status_i.out_free) begin
          cmd_o.create = 1'b1;
          cmd_o.emit   = 1'b1;
          cmd_o.kind   = KIND_CREATE;
          cmd_o.last   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_REMOVE: begin
        if (status_i.out_free) begin
          cmd_o.remove = 1'b1;
          cmd_o.emit   = 1'b1;
          cmd_o.kind   = KIND_REMOVE;
          cmd_o.last   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  `STB_ASSERT(a_scan_holds, (state_q == ST_SCAN && status_i.hit && !status_i.out_free) |=> (state_q == ST_SCAN && $stable(idx_q)), "scan moved past a stalled fire")
  `STB_ASSERT(a_last_ends, (cmd_o.emit && cmd_o.last) |=> (state_q == ST_IDLE), "final beat did not end the item")
  `STB_ASSERT(a_fire_not_last, (cmd_o.emit && cmd_o.kind == KIND_FIRED) |-> !cmd_o.last, "fire beat marked last")

endmodule

// ----- sv/stb_dp.sv -----
// Datapath: config, slot table, time accumulators and output register.
`include "assert_macros.svh"
module stb_dp import stb_pkg::*; #(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
  localparam int IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  stb_cmd_t              cmd_i,
  input  logic [IdxW-1:0]       scan_idx_i,
  output stb_status_t           status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic [1:0]            out_kind_o,
  output logic                  out_last_o
);

  // Config
  logic [9:0]  tpm_q, mwhole_q;
  logic [31:0] mfrac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q    <= TICK_RATE_RST;
      mwhole_q <= MS_WHOLE_RST;
      mfrac_q  <= MS_FRACTION_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_TICK_RATE:    tpm_q    <= cfg_wdata_i[9:0];
        CFG_MS_WHOLE:     mwhole_q <= cfg_wdata_i[9:0];
        CFG_MS_FRACTION:  mfrac_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Captured input beat
  logic [19:0] delay_q;
  logic        oneshot_q;
  logic [31:0] uarg_q;
  logic [3:0]  id_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      delay_q   <= in_data_i[19:0];
      oneshot_q <= in_data_i[20];
      uarg_q    <= in_data_i[52:21];
      id_q      <= in_data_i[56:53];
    end
  end

  // Time accumulators
  logic [31:0] tick_q;
  logic [31:0] frac_q;
  logic [10:0] whole_q;
  logic [63:0] sec_q;
  logic [32:0] frac_sum;
  logic [11:0] whole_sum;
  logic        roll;

  assign frac_sum  = {1'b0, frac_q} + {1'b0, mfrac_q};
  assign whole_sum = {1'b0, whole_q} + {11'd0, frac_sum[32]} + {2'd0, mwhole_q};
  assign roll      = (whole_sum >= MS_PER_SECOND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      frac_q  <= '0;
      whole_q <= '0;
      sec_q   <= '0;
    end else if (cmd_i.advance) begin
      tick_q  <= tick_q + 32'd1;
      frac_q  <= frac_sum[31:0];
      whole_q <= roll ? 11'(whole_sum - MS_PER_SECOND) : whole_sum[10:0];
      if (roll) begin
        sec_q <= sec_q + 64'd1;
      end
    end
  end

  // Slot table
  logic [1:0]  mode_q     [TIMER_SLOTS];
  logic [31:0] deadline_q [TIMER_SLOTS];
  logic [31:0] period_q   [TIMER_SLOTS];
  logic [31:0] arg_q      [TIMER_SLOTS];

  logic [1:0]      sel_mode;
  logic [31:0]     sel_dl;
  logic            hit;
  logic            fire;
  logic [29:0]     prod_q;
  logic            found_q, found;
  logic [IdxW-1:0] fidx_q, fidx;
  logic            rm_ok;
  logic [IdxW-1:0] rm_idx;

  assign sel_mode = mode_q[scan_idx_i];
  assign sel_dl   = deadline_q[scan_idx_i];
  assign hit      = (sel_dl != '0) && (sel_dl <= tick_q) &&
                    ((sel_mode == MODE_ONESHOT) || (sel_mode == MODE_PERIODIC));
  assign fire     = cmd_i.scan && hit;
  assign rm_ok    = ({1'b0, id_q} < 5'(TIMER_SLOTS));
  assign rm_idx   = id_q[IdxW-1:0];

  // highest free slot wins
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (mode_q[i] == MODE_FREE) begin
        found = 1'b1;
        fidx  = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q  <= 30'(delay_q) * 30'(tpm_q);
      found_q <= found;
      fidx_q  <= fidx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        mode_q[i]     <= MODE_FREE;
        deadline_q[i] <= '0;
      end
    end else begin
      if (fire) begin
        if (sel_mode == MODE_ONESHOT) begin
          mode_q[scan_idx_i]     <= MODE_FREE;
          deadline_q[scan_idx_i] <= '0;
        end else begin
          deadline_q[scan_idx_i] <= tick_q + period_q[scan_idx_i];
        end
      end
      if (cmd_i.create && found_q) begin
        mode_q[fidx_q]     <= oneshot_q ? MODE_ONESHOT : MODE_PERIODIC;
        deadline_q[fidx_q] <= tick_q + {2'd0, prod_q};
      end
      if (cmd_i.remove && rm_ok) begin
        mode_q[rm_idx]     <= MODE_FREE;
        deadline_q[rm_idx] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.create && found_q) begin
      period_q[fidx_q] <= {2'd0, prod_q};
      arg_q[fidx_q]    <= uarg_q;
    end
  end

  // Output register
  logic         out_valid_q;
  result_kind_e out_kind_q;
  logic         out_last_q;
  logic [3:0]   out_slot_q, slot_d;
  logic [31:0]  out_arg_q, arg_d;
  logic         out_ok_q, ok_d;
  logic [31:0]  out_tick_q;
  logic [10:0]  out_ms_q;
  logic [63:0]  out_sec_q;
  logic         out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    slot_d = '0;
    arg_d  = '0;
    ok_d   = 1'b0;
    case (cmd_i.kind)
      KIND_FIRED: begin
        slot_d = 4'(scan_idx_i);
        arg_d  = arg_q[scan_idx_i];
      end
      KIND_CREATE: begin
        slot_d = found_q ? 4'(fidx_q) : 4'd0;
        ok_d   = found_q;
      end
      KIND_REMOVE: begin
        slot_d = id_q;
        ok_d   = rm_ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.kind;
      out_last_q <= cmd_i.last;
      out_slot_q <= slot_d;
      out_arg_q  <= arg_d;
      out_ok_q   <= ok_d;
      out_tick_q <= tick_q;
      out_ms_q   <= whole_q;
      out_sec_q  <= sec_q;
    end
  end

  assign status_o.hit      = hit;
  assign status_o.out_free = out_free;
  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {out_sec_q, out_ms_q, out_tick_q, out_ok_q, out_arg_q, out_slot_q};

  `STB_ASSERT(a_emit_room, cmd_i.emit |-> out_free, "beat loaded over an untaken beat")
  `STB_ASSERT(a_fire_emits, (cmd_i.scan && hit) |-> cmd_i.emit, "slot fired without a beat")
  `STB_ASSERT_ALWAYS(a_no_adv_busy, (cmd_i.advance && rst_ni) |-> cmd_i.latch, "advance outside accept")

endmodule

// ----- sv/software_timer_bank.sv -----
// Top level of the timer bank: stream ports, config port, controller and datapath.
// Tick: accept (counters advance), scan of all slots from the top down, status beat;
//   a result beat waits while the output register is full.
// Create: accept, period multiply, slot write and reply; remove, no-op: accept, reply.
// Next command beat is taken the cycle after the final result beat loads.
// rst_ni low clears slots to free, counters to zero, config to defaults; no clear pass.
module software_timer_bank import stb_pkg::*; #(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Command stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // delay_ms[19:0], one_shot[20], user_arg[52:21], slot_id[56:53], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [1:0]            s_axis_tuser,
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // slot_index[3:0], fired_arg[35:4], success[36], tick_count[68:37],
  // ms_within_second[79:69], seconds[143:80]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // result_kind[1:0]
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  stb_cmd_t        cmd;
  stb_status_t     status;
  logic [IdxW-1:0] scan_idx;

  // Controller sees command code, handshake and status; payload goes to the datapath.
  stb_ctrl #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .scan_idx_o (scan_idx)
  );

  // Datapath owns the slot table and the output register, so the next
  // command beat is taken while the last result beat still waits.
  stb_dp #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .scan_idx_i  (scan_idx),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
